// ----- rtl/ssl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, codes and tables of the seven-segment lcd formatter.
// ----------------------------------------------------------------------------
package ssl_pkg;

    localparam int RAM_WORDS_DEF = 18;
    localparam int DIGIT_COUNT   = 4;
    localparam int SEG_COUNT     = 7;

    localparam logic [2:0] ACT_CLEAR     = 3'd0;
    localparam logic [2:0] ACT_PAIRS     = 3'd1;
    localparam logic [2:0] ACT_PREFIX    = 3'd2;
    localparam logic [2:0] ACT_ERROR     = 3'd3;
    localparam logic [2:0] ACT_INDICATOR = 3'd4;

    localparam logic [2:0] IND_WORK  = 3'd3;
    localparam logic [2:0] IND_COLON = 3'd4;
    localparam logic [2:0] IND_TIME  = 3'd5;

    localparam logic [4:0] IND_WORD_A = 5'd14;
    localparam logic [4:0] IND_WORD_B = 5'd15;
    localparam logic [4:0] ZERO_WORD_LO = 5'd13;
    localparam logic [4:0] ZERO_WORD_HI = 5'd15;

    localparam logic [6:0]  SEG_DASH   = 7'h40;
    localparam logic [6:0]  SEG_E      = 7'h79;
    localparam logic [6:0]  SEG_R      = 7'h50;
    localparam logic [15:0] NUM_LIMIT  = 16'd999;
    localparam logic [7:0]  PAIR_SKIP  = 8'hFF;
    localparam logic [7:0]  ERR_LIMIT  = 8'd99;
    localparam logic [2:0]  NO_SLOT    = 3'd7;

    // ram word of each segment, a through g
    localparam logic [4:0] SEG_WORD [SEG_COUNT] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd13
    };

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  value_a;
        logic [15:0] value_b;
        logic [2:0]  indicator;
        logic        indicator_on;
    } t_in_req;

    typedef struct packed {
        logic [4:0] ram_address;
        logic [3:0] ram_nibble;
        logic       last_write;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV0,
        ST_DIV1,
        ST_CLEAR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic div_first;
        logic div_second;
        logic frame_go;
        logic clear_pass;
        logic last;
    } t_ctrl;

    // segments gfedcba of a decimal digit, blank for 10 and up
    function automatic logic [6:0] glyph_of(input logic [6:0] d);
        logic [6:0] g;
        case (d)
            7'd0:    g = 7'h3F;
            7'd1:    g = 7'h06;
            7'd2:    g = 7'h5B;
            7'd3:    g = 7'h4F;
            7'd4:    g = 7'h66;
            7'd5:    g = 7'h6D;
            7'd6:    g = 7'h7D;
            7'd7:    g = 7'h07;
            7'd8:    g = 7'h7F;
            7'd9:    g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    // segment slot held by a ram word, NO_SLOT when none
    function automatic logic [2:0] seg_slot(input logic [4:0] a);
        logic [2:0] s;
        s = NO_SLOT;
        for (int i = 0; i < SEG_COUNT; i++) begin
            if (a == SEG_WORD[i]) s = 3'(i);
        end
        return s;
    endfunction

endpackage

// ----- rtl/ssl_div10.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_div10
// Shared divide-by-ten unit: quotient and remainder of a 10-bit value.
// ----------------------------------------------------------------------------
module ssl_div10 (
    input  logic [9:0] i_value,
    output logic [6:0] o_quot,
    output logic [3:0] o_rem
);

    logic [17:0] prod;
    logic [9:0]  quot_x10;

    // x / 10 == (x * 205) >> 11 for x below 1029
    assign prod     = 18'(i_value) * 18'd205;
    assign o_quot   = prod[17:11];
    assign quot_x10 = 10'({o_quot, 3'b000}) + 10'({o_quot, 1'b0});
    assign o_rem    = 4'(i_value - quot_x10);

endmodule

// ----- rtl/ssl_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_seq
// Sequencer: two divide steps for pair, prefix and error actions, a clear pass for errors, then one frame per word.
// ----------------------------------------------------------------------------
module ssl_seq
    import ssl_pkg::*;
#(
    parameter int RAM_WORDS = RAM_WORDS_DEF,
    parameter int ADDR_W    = $clog2(RAM_WORDS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_new_action,
    input  logic [2:0]        i_action,
    input  logic              i_slot_free,
    output t_ctrl             o_ctrl,
    output logic [ADDR_W-1:0] o_addr
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RAM_WORDS - 1);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              at_last;

    assign at_last = (r_addr == LAST_ADDR);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_new_action)
                        ACT_CLEAR, ACT_INDICATOR:        n_state = ST_EMIT;
                        ACT_PAIRS, ACT_PREFIX, ACT_ERROR: n_state = ST_DIV0;
                        default:                         n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV0: n_state = ST_DIV1;
            ST_DIV1: n_state = (i_action == ACT_ERROR) ? ST_CLEAR : ST_EMIT;
            ST_CLEAR: begin
                if (i_slot_free && at_last) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_slot_free && at_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            ST_IDLE: o_ctrl.busy = 1'b0;
            ST_DIV0: begin
                o_ctrl.busy      = 1'b1;
                o_ctrl.div_first = 1'b1;
            end
            ST_DIV1: begin
                o_ctrl.busy       = 1'b1;
                o_ctrl.div_second = 1'b1;
            end
            ST_CLEAR: begin
                o_ctrl.busy       = 1'b1;
                o_ctrl.frame_go   = i_slot_free;
                o_ctrl.clear_pass = 1'b1;
            end
            ST_EMIT: begin
                o_ctrl.busy     = 1'b1;
                o_ctrl.frame_go = i_slot_free;
                o_ctrl.last     = at_last;
            end
            default: o_ctrl = '0;
        endcase
    end

    always_comb begin
        n_addr = r_addr;
        if (o_ctrl.frame_go) begin
            n_addr = at_last ? '0 : r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_addr = r_addr;

endmodule

// ----- rtl/seven_segment_lcd_formatter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_lcd_formatter
// Formats display actions into segment ram write frames for a 4-digit lcd.
// ----------------------------------------------------------------------------
// Usage
//   Input channel i_in_valid / o_in_stall / i_in_data carries one action
//   request. Output channel o_out_valid / i_out_stall / o_out_data carries
//   write frames (address, nibble, last flag); every action emits one frame
//   per ram word from address 0 upward, and the error action emits a
//   zeroed frame set first. Actions 5 to 7 are taken and dropped.
//   Timing: the request is taken, the shared divide-by-ten unit runs
//   two steps (pair, prefix and error actions), then one frame is
//   produced per cycle into the output register while the output does
//   not stall; each frame also updates that ram word. Clear and
//   indicator actions skip the divide steps and go straight to the
//   frames. o_in_stall is high for the whole time a request is in work.
//   Reset loads the segment ram with all ones except words 13 to 15 at
//   zero. A stall on the output holds the frame and pauses the sequencer.
// ----------------------------------------------------------------------------
module seven_segment_lcd_formatter
    import ssl_pkg::*;
#(
    parameter int RAM_WORDS = RAM_WORDS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    localparam int ADDR_W = $clog2(RAM_WORDS);

    t_ctrl             ctrl;
    logic [ADDR_W-1:0] addr;
    logic [4:0]        addr5;
    logic              in_acc;
    logic              slot_free;

    t_in_req    r_req;
    logic [6:0] r_q0, r_q1;
    logic [3:0] r_r0, r_r1;
    logic [3:0] r_ram [RAM_WORDS];
    t_out_req   r_out;
    logic       r_out_valid;

    logic [9:0] div_in;
    logic [6:0] div_q;
    logic [3:0] div_r;

    logic [6:0]             glyph [DIGIT_COUNT];
    logic [DIGIT_COUNT-1:0] wmask;
    logic                   big;
    logic [2:0]             slot;
    logic [3:0]             base;
    logic [3:0]             n_nib;

    assign in_acc     = i_in_valid && !ctrl.busy;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = ctrl.busy;

    ssl_seq #(
        .RAM_WORDS (RAM_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_acc),
        .i_new_action (i_in_data.action),
        .i_action     (r_req.action),
        .i_slot_free  (slot_free),
        .o_ctrl       (ctrl),
        .o_addr       (addr)
    );

    // first pass splits value_a (or the prefix number), second the right pair
    // or the hundreds out of the first quotient
    always_comb begin
        if (ctrl.div_second) begin
            div_in = (r_req.action == ACT_PREFIX) ? 10'(r_q0) : 10'(r_req.value_b[7:0]);
        end else begin
            div_in = (r_req.action == ACT_PREFIX) ? r_req.value_b[9:0] : 10'(r_req.value_a);
        end
    end

    ssl_div10 u_div (
        .i_value (div_in),
        .o_quot  (div_q),
        .o_rem   (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) r_req <= i_in_data;
        if (ctrl.div_first) begin
            r_q0 <= div_q;
            r_r0 <= div_r;
        end
        if (ctrl.div_second) begin
            r_q1 <= div_q;
            r_r1 <= div_r;
        end
    end

    // digit glyphs and which digits this action rewrites
    assign big = (r_req.value_b > NUM_LIMIT);

    always_comb begin
        for (int p = 0; p < DIGIT_COUNT; p++) glyph[p] = '0;
        wmask = '0;
        case (r_req.action)
            ACT_PAIRS: begin
                glyph[0] = glyph_of(r_q0);
                glyph[1] = glyph_of(7'(r_r0));
                glyph[2] = glyph_of(r_q1);
                glyph[3] = glyph_of(7'(r_r1));
                wmask[0] = (r_req.value_a != PAIR_SKIP);
                wmask[1] = (r_req.value_a != PAIR_SKIP);
                wmask[2] = (r_req.value_b[7:0] != PAIR_SKIP);
                wmask[3] = (r_req.value_b[7:0] != PAIR_SKIP);
            end
            ACT_PREFIX: begin
                glyph[0] = r_req.value_a[6:0];
                if (big) begin
                    glyph[1] = SEG_DASH;
                    glyph[2] = SEG_DASH;
                    glyph[3] = SEG_DASH;
                end else begin
                    glyph[1] = (r_q1 == 7'd0) ? 7'h00 : glyph_of(r_q1);
                    glyph[2] = (r_q1 == 7'd0 && r_r1 == 4'd0) ? 7'h00 : glyph_of(7'(r_r1));
                    glyph[3] = glyph_of(7'(r_r0));
                end
                wmask = '1;
            end
            ACT_ERROR: begin
                glyph[0] = SEG_E;
                glyph[1] = SEG_R;
                if (r_req.value_a < ERR_LIMIT) begin
                    glyph[2] = glyph_of(r_q0);
                    glyph[3] = glyph_of(7'(r_r0));
                end else begin
                    glyph[2] = SEG_E;
                    glyph[3] = SEG_R;
                end
                wmask = '1;
            end
            default: wmask = '0;
        endcase
    end

    assign addr5 = 5'(addr);
    assign slot  = seg_slot(addr5);
    assign base  = r_ram[addr];

    // new content of the word being sent; digit pos owns bit 3-pos
    always_comb begin
        n_nib = base;
        if (ctrl.clear_pass) begin
            n_nib = '0;
        end else begin
            case (r_req.action)
                ACT_CLEAR: n_nib = '0;
                ACT_PAIRS, ACT_PREFIX, ACT_ERROR: begin
                    if (slot != NO_SLOT) begin
                        for (int p = 0; p < DIGIT_COUNT; p++) begin
                            if (wmask[p]) n_nib[3-p] = glyph[p][slot];
                        end
                    end
                end
                ACT_INDICATOR: begin
                    if (addr5 == IND_WORD_A && r_req.indicator <= IND_WORK) begin
                        n_nib[~r_req.indicator[1:0]] = r_req.indicator_on;
                    end else if (addr5 == IND_WORD_B && r_req.indicator == IND_COLON) begin
                        n_nib[3] = r_req.indicator_on;
                    end else if (addr5 == IND_WORD_B && r_req.indicator == IND_TIME) begin
                        n_nib[2] = r_req.indicator_on;
                    end
                end
                default: n_nib = base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RAM_WORDS; i++) begin
                r_ram[i] <= (5'(i) >= ZERO_WORD_LO && 5'(i) <= ZERO_WORD_HI) ? 4'h0 : 4'hF;
            end
        end else if (ctrl.frame_go) begin
            r_ram[addr] <= n_nib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.frame_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.frame_go) begin
            r_out.ram_address <= addr5;
            r_out.ram_nibble  <= n_nib;
            r_out.last_write  <= ctrl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a new frame never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.frame_go |-> (!r_out_valid || !i_out_stall))
        else $error("frame loaded over a pending frame");

    // frames only come while a request is in work
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.frame_go |-> ctrl.busy)
        else $error("frame produced while idle");

    // the closing frame is always the top ram word
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_write) |->
            (o_out_data.ram_address == 5'(RAM_WORDS - 1)))
        else $error("last frame not at top address");

    // after the last frame is loaded the block takes requests again
    a_free_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.frame_go && ctrl.last) |=> !ctrl.busy)
        else $error("sequencer busy after last frame");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.ram_address < 5'(RAM_WORDS)))
        else $error("frame address out of range");

endmodule

// ----- verif/seven_segment_lcd_formatter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_lcd_formatter_tb
// Self-checking bench: drives display actions into the formatter, predicts
// the segment ram image and compares every write frame in order.
// ----------------------------------------------------------------------------
module seven_segment_lcd_formatter_tb;
    import ssl_pkg::*;

    // tracks the segment ram image and the write frames still owed
    class frame_scoreboard;
        logic [3:0] ram [RAM_WORDS_DEF];
        logic [6:0] digit_segs [10];
        int         seg_word [SEG_COUNT];
        t_out_req   frames_due [$];
        int         mismatches;

        function new();
            digit_segs = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                           7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
            seg_word   = '{0, 1, 2, 3, 4, 5, 13};
            mismatches = 0;
            for (int i = 0; i < RAM_WORDS_DEF; i++) begin
                ram[i] = (i >= ZERO_WORD_LO && i <= ZERO_WORD_HI) ? 4'h0 : 4'hF;
            end
        endfunction

        function logic [6:0] decimal_segs(int d);
            return (d >= 0 && d < 10) ? digit_segs[d] : 7'h00;
        endfunction

        function void put_digit(int pos, logic [6:0] segs);
            logic [3:0] mask;
            mask = 4'b1000 >> pos;
            for (int i = 0; i < SEG_COUNT; i++) begin
                if (segs[i]) ram[seg_word[i]] = ram[seg_word[i]] | mask;
                else ram[seg_word[i]] = ram[seg_word[i]] & ~mask;
            end
        endfunction

        function void wipe_ram();
            for (int i = 0; i < RAM_WORDS_DEF; i++) ram[i] = 4'h0;
        endfunction

        function void queue_frames(bit mark_last);
            t_out_req f;
            for (int a = 0; a < RAM_WORDS_DEF; a++) begin
                f.ram_address = 5'(a);
                f.ram_nibble  = ram[a];
                f.last_write  = mark_last && (a == RAM_WORDS_DEF - 1);
                frames_due.push_back(f);
            end
        endfunction

        function void note_request(t_in_req r);
            int h;
            int t;
            int o;
            int right;
            case (r.action)
                ACT_CLEAR: begin
                    wipe_ram();
                end
                ACT_PAIRS: begin
                    right = r.value_b[7:0];
                    if (r.value_a != PAIR_SKIP) begin
                        put_digit(0, decimal_segs(r.value_a / 10));
                        put_digit(1, decimal_segs(r.value_a % 10));
                    end
                    if (r.value_b[7:0] != PAIR_SKIP) begin
                        put_digit(2, decimal_segs(right / 10));
                        put_digit(3, decimal_segs(right % 10));
                    end
                end
                ACT_PREFIX: begin
                    put_digit(0, r.value_a[6:0]);
                    if (r.value_b > NUM_LIMIT) begin
                        put_digit(1, SEG_DASH);
                        put_digit(2, SEG_DASH);
                        put_digit(3, SEG_DASH);
                    end else begin
                        h = r.value_b / 100;
                        t = (r.value_b / 10) % 10;
                        o = r.value_b % 10;
                        // leading zero blanking on the two upper digits
                        put_digit(1, (h == 0) ? 7'h00 : decimal_segs(h));
                        put_digit(2, (h == 0 && t == 0) ? 7'h00 : decimal_segs(t));
                        put_digit(3, decimal_segs(o));
                    end
                end
                ACT_ERROR: begin
                    wipe_ram();
                    queue_frames(1'b0);
                    put_digit(0, SEG_E);
                    put_digit(1, SEG_R);
                    if (r.value_a < ERR_LIMIT) begin
                        put_digit(2, decimal_segs(r.value_a / 10));
                        put_digit(3, decimal_segs(r.value_a % 10));
                    end else begin
                        put_digit(2, SEG_E);
                        put_digit(3, SEG_R);
                    end
                end
                ACT_INDICATOR: begin
                    if (r.indicator <= IND_WORK)
                        ram[IND_WORD_A][3 - int'(r.indicator)] = r.indicator_on;
                    else if (r.indicator == IND_COLON)
                        ram[IND_WORD_B][3] = r.indicator_on;
                    else if (r.indicator == IND_TIME)
                        ram[IND_WORD_B][2] = r.indicator_on;
                end
                default: begin
                    // unknown actions are dropped without frames
                    return;
                end
            endcase
            queue_frames(1'b1);
        endfunction

        function void check_frame(t_out_req got);
            t_out_req want;
            if (frames_due.size() == 0) begin
                $error("frame with none due: ram_address %0d ram_nibble %h last_write %b",
                       got.ram_address, got.ram_nibble, got.last_write);
                mismatches++;
                return;
            end
            want = frames_due.pop_front();
            if (got.ram_address !== want.ram_address) begin
                $error("ram_address: expected %0d, actual %0d",
                       want.ram_address, got.ram_address);
                mismatches++;
            end
            if (got.ram_nibble !== want.ram_nibble) begin
                $error("ram_nibble: expected %h, actual %h",
                       want.ram_nibble, got.ram_nibble);
                mismatches++;
            end
            if (got.last_write !== want.last_write) begin
                $error("last_write: expected %b, actual %b",
                       want.last_write, got.last_write);
                mismatches++;
            end
        endfunction
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_data;

    frame_scoreboard sb = new();

    bit stall_on = 1'b0;
    bit gaps_on  = 1'b0;
    int hold_len = 0;

    seven_segment_lcd_formatter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_frame(o_out_data);
    end

    // receiver: stretches of stall and no stall, plus a requested long hold
    initial begin : out_side
        int run;
        int roll;
        bit level;
        wait (i_rst_n);
        forever begin
            if (hold_len > 0) begin
                level    = 1'b1;
                run      = hold_len;
                hold_len = 0;
            end else if (!stall_on) begin
                level = 1'b0;
                run   = 1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    level = 1'b0;
                    run   = $urandom_range(1, 8);
                end else if (roll < 92) begin
                    level = 1'b1;
                    run   = $urandom_range(1, 3);
                end else begin
                    level = 1'b1;
                    run   = $urandom_range(10, 40);
                end
            end
            i_out_stall <= level;
            repeat (run) @(posedge i_clk);
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_in_req make_req(logic [2:0] act, logic [7:0] va,
                                         logic [15:0] vb, logic [2:0] ind, logic on);
        t_in_req r;
        r.action       = act;
        r.value_a      = va;
        r.value_b      = vb;
        r.indicator    = ind;
        r.indicator_on = on;
        return r;
    endfunction

    function automatic t_in_req random_request();
        t_in_req r;
        int roll;
        int pick;
        r.value_a      = 8'($urandom_range(0, 255));
        r.value_b      = 16'($urandom_range(0, 65535));
        r.indicator    = 3'($urandom_range(0, 7));
        r.indicator_on = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            r.action = ACT_CLEAR;
        end else if (roll < 38) begin
            r.action = ACT_PAIRS;
            pick = $urandom_range(0, 99);
            if (pick < 70) r.value_a = 8'($urandom_range(0, 99));
            else if (pick < 85) r.value_a = PAIR_SKIP;
            pick = $urandom_range(0, 99);
            if (pick < 70) r.value_b[7:0] = 8'($urandom_range(0, 99));
            else if (pick < 85) r.value_b[7:0] = PAIR_SKIP;
        end else if (roll < 63) begin
            r.action = ACT_PREFIX;
            pick = $urandom_range(0, 4);
            case (pick)
                0: r.value_b = 16'($urandom_range(0, 9));
                1: r.value_b = 16'($urandom_range(0, 99));
                2: r.value_b = 16'($urandom_range(0, 999));
                3: r.value_b = 16'($urandom_range(990, 1010));
                default: ;
            endcase
        end else if (roll < 73) begin
            r.action = ACT_ERROR;
            if ($urandom_range(0, 3) != 0) r.value_a = 8'($urandom_range(0, 98));
        end else if (roll < 97) begin
            r.action = ACT_INDICATOR;
        end else begin
            r.action = 3'($urandom_range(5, 7));
        end
        return r;
    endfunction

    task automatic send_request(input t_in_req r);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.frames_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin : limit
        #50_000_000;
        $display("seven_segment_lcd_formatter_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int counted;
        t_in_req r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling on either side
        send_request(make_req(ACT_CLEAR, 8'd0, 16'd0, 3'd0, 1'b0));
        send_request(make_req(ACT_PAIRS, 8'd0, 16'd0, 3'd0, 1'b0));
        send_request(make_req(ACT_PAIRS, 8'd99, 16'd99, 3'd0, 1'b0));
        send_request(make_req(ACT_PAIRS, PAIR_SKIP, 16'hFF37, 3'd0, 1'b0));
        send_request(make_req(ACT_PAIRS, 8'd12, 16'h00FF, 3'd0, 1'b0));
        send_request(make_req(ACT_PAIRS, 8'd200, 16'h0064, 3'd0, 1'b0));
        send_request(make_req(ACT_PREFIX, 8'hFF, 16'd0, 3'd0, 1'b0));
        send_request(make_req(ACT_PREFIX, 8'h00, 16'd7, 3'd0, 1'b0));
        send_request(make_req(ACT_PREFIX, 8'h3F, 16'd42, 3'd0, 1'b0));
        send_request(make_req(ACT_PREFIX, 8'h55, 16'd305, 3'd0, 1'b0));
        send_request(make_req(ACT_PREFIX, 8'h80, NUM_LIMIT, 3'd0, 1'b0));
        send_request(make_req(ACT_PREFIX, 8'h7F, 16'd1000, 3'd0, 1'b0));
        send_request(make_req(ACT_PREFIX, 8'h01, 16'hFFFF, 3'd0, 1'b0));
        for (int i = 0; i < 8; i++) begin
            send_request(make_req(ACT_INDICATOR, 8'd0, 16'd0, 3'(i), 1'b1));
        end
        send_request(make_req(ACT_INDICATOR, 8'd0, 16'd0, 3'd2, 1'b0));
        // error wipes the indicators lit above
        send_request(make_req(ACT_ERROR, 8'd0, 16'd0, 3'd0, 1'b0));
        send_request(make_req(ACT_ERROR, 8'd98, 16'd0, 3'd0, 1'b0));
        send_request(make_req(ACT_ERROR, ERR_LIMIT, 16'd0, 3'd0, 1'b0));
        send_request(make_req(ACT_ERROR, 8'hFF, 16'hFFFF, 3'd7, 1'b1));
        for (int a = 5; a < 8; a++) begin
            send_request(make_req(3'(a), 8'hFF, 16'hFFFF, 3'd7, 1'b1));
        end
        i_in_valid <= 1'b0;
        wait_drained();

        // long receiver hold while requests keep coming
        hold_len = 300;
        repeat (20) send_request(random_request());

        stall_on = 1'b1;
        gaps_on  = 1'b1;
        counted  = 0;
        while (counted < 430) begin
            // a stretch with no idling on either side
            stall_on = !(counted >= 200 && counted < 260);
            gaps_on  = stall_on;
            r = random_request();
            if (r.action <= ACT_INDICATOR) counted++;
            send_request(r);
        end
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.frames_due.size() == 0) begin
            $display("seven_segment_lcd_formatter_tb: PASS");
        end else begin
            $display("seven_segment_lcd_formatter_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- seven_segment_lcd_formatter.f -----
rtl/ssl_pkg.sv
rtl/ssl_div10.sv
rtl/ssl_seq.sv
rtl/seven_segment_lcd_formatter.sv
verif/seven_segment_lcd_formatter_tb.sv
